### design/scba_pkg.sv
`timescale 1ns / 1ps

package scba_pkg;

    localparam int NUM_POOLS  = 4;
    localparam int MAX_BLOCKS = 16;
    localparam int NUM_TYPES  = 16;

    localparam int POOL_W = $clog2(NUM_POOLS);
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SLOTS  = NUM_POOLS * MAX_BLOCKS;
    localparam int SLOT_W = POOL_W + IDX_W;

    // fixed field widths of the word and the registers
    localparam int MODE_W   = 2;
    localparam int TYPE_W   = 4;
    localparam int SIZE_W   = 16;
    localparam int CNTF_W   = 5;
    localparam int STATUS_W = 2;
    localparam int HPOOL_W  = 2;
    localparam int HIDX_W   = 4;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADHDL = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TYPE_W-1:0]  req_type;
        logic [SIZE_W-1:0]  req_size;
        logic [HPOOL_W-1:0] handle_pool;
        logic [HIDX_W-1:0]  handle_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HPOOL_W-1:0]  out_pool;
        logic [HIDX_W-1:0]   out_index;
        logic [CNTF_W-1:0]   pool_free_left;
    } t_result;

    typedef struct packed {
        logic [15:0] pool_types;
        logic [63:0] pool_block_sizes;
        logic [19:0] pool_counts;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic              exec;
        logic              sweep_we;
        logic              sweep_last;
        logic [SLOT_W-1:0] sweep_addr;
    } t_cmd;

    typedef struct packed {
        logic rebuild_req;
    } t_stat;

endpackage

### design/scba_ctrl.sv
`timescale 1ns / 1ps

module scba_ctrl import scba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_sweep_addr, n_sweep_addr;
    logic              load;

    assign load   = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state      = i_stat.rebuild_req ? S_SWEEP : S_EXEC;
                    n_sweep_addr = '0;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            S_SWEEP: begin
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (r_sweep_addr == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sweep_addr <= '0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
        end
    end

    always_comb begin
        o_cmd.load       = load;
        o_cmd.exec       = (r_state == S_EXEC);
        o_cmd.sweep_we   = (r_state == S_SWEEP);
        o_cmd.sweep_last = (r_state == S_SWEEP) && (r_sweep_addr == SLOT_W'(SLOTS - 1));
        o_cmd.sweep_addr = r_sweep_addr;
    end

endmodule

### design/scba_dp.sv
`timescale 1ns / 1ps

module scba_dp import scba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_req    i_req,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output logic    o_done,
    output t_result o_result
);

    // free stacks, one row of MAX_BLOCKS per pool
    logic [IDX_W-1:0]  r_mem [SLOTS];
    logic [IDX_W-1:0]  r_rd_data;

    logic [CNT_W-1:0]  r_free_cnt [NUM_POOLS];
    logic [CNT_W-1:0]  n_free_cnt [NUM_POOLS];
    logic [SLOTS-1:0]  r_in_use, n_in_use;

    t_req              r_req;
    logic              r_hit;
    logic [POOL_W-1:0] r_pick;

    logic              r_done;
    t_result           r_res, n_res;

    logic              req_bad;
    logic              hit;
    logic [POOL_W-1:0] pick;
    logic [CNT_W-1:0]  pick_top;
    logic [SLOT_W-1:0] rd_addr;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [IDX_W-1:0]  mem_wdata;

    logic [POOL_W-1:0] rel_pool;
    logic [IDX_W-1:0]  rel_idx;
    logic              rel_ok;
    logic [CNT_W-1:0]  rel_cnt;
    logic [CNT_W-1:0]  alloc_top;

    assign o_stat.rebuild_req = (i_req.mode == MODE_REBUILD);

    assign req_bad = (i_req.req_size == '0) || (32'(i_req.req_type) >= NUM_TYPES);

    // first pool that fits, from the incoming word
    always_comb begin
        hit  = 1'b0;
        pick = '0;
        for (int p = NUM_POOLS - 1; p >= 0; p--) begin
            if (i_cfg.pool_types[p*TYPE_W +: TYPE_W] == i_req.req_type &&
                i_cfg.pool_block_sizes[p*SIZE_W +: SIZE_W] >= i_req.req_size &&
                r_free_cnt[p] != '0 && !req_bad) begin
                hit  = 1'b1;
                pick = POOL_W'(p);
            end
        end
        pick_top = r_free_cnt[pick] - 1'b1;
        rd_addr  = {pick, pick_top[IDX_W-1:0]};
    end

    // release decode from the latched word
    always_comb begin
        rel_pool = r_req.handle_pool[POOL_W-1:0];
        rel_idx  = r_req.handle_index[IDX_W-1:0];
        rel_cnt  = r_free_cnt[rel_pool];
        rel_ok   = (32'(r_req.handle_pool) < NUM_POOLS) &&
                   (32'(r_req.handle_index) < MAX_BLOCKS) &&
                   r_in_use[{rel_pool, rel_idx}] &&
                   (rel_cnt < CNT_W'(MAX_BLOCKS));
        alloc_top = r_free_cnt[r_pick] - 1'b1;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_cmd.sweep_addr;
        mem_wdata = i_cmd.sweep_addr[IDX_W-1:0];
        if (i_cmd.sweep_we) begin
            mem_we = 1'b1;
        end else if (i_cmd.exec && r_req.mode == MODE_RELEASE && rel_ok) begin
            mem_we    = 1'b1;
            mem_waddr = {rel_pool, rel_cnt[IDX_W-1:0]};
            mem_wdata = rel_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        logic [CNT_W-1:0] cfg_cnt;
        cfg_cnt    = '0;
        n_free_cnt = r_free_cnt;
        n_in_use   = r_in_use;
        n_res      = '0;
        n_res.status = ST_BAD;
        if (i_cmd.load && o_stat.rebuild_req) begin
            n_in_use = '0;
            for (int p = 0; p < NUM_POOLS; p++) begin
                cfg_cnt = CNT_W'(i_cfg.pool_counts[p*CNTF_W +: CNTF_W]);
                n_free_cnt[p] = (cfg_cnt > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_cnt;
            end
        end
        if (i_cmd.exec) begin
            case (r_req.mode)
                MODE_ALLOC: begin
                    if (r_hit) begin
                        n_free_cnt[r_pick]          = alloc_top;
                        n_in_use[{r_pick, r_rd_data}] = 1'b1;
                        n_res.status         = ST_OK;
                        n_res.out_pool       = HPOOL_W'(r_pick);
                        n_res.out_index      = HIDX_W'(r_rd_data);
                        n_res.pool_free_left = CNTF_W'(alloc_top);
                    end else if ((r_req.req_size == '0) ||
                                 (32'(r_req.req_type) >= NUM_TYPES)) begin
                        n_res.status = ST_BAD;
                    end else begin
                        n_res.status = ST_NOFIT;
                    end
                end
                MODE_RELEASE: begin
                    if (rel_ok) begin
                        n_free_cnt[rel_pool]          = rel_cnt + 1'b1;
                        n_in_use[{rel_pool, rel_idx}] = 1'b0;
                        n_res.status         = ST_OK;
                        n_res.out_pool       = r_req.handle_pool;
                        n_res.out_index      = r_req.handle_index;
                        n_res.pool_free_left = CNTF_W'(rel_cnt + 1'b1);
                    end else begin
                        n_res.status = ST_BADHDL;
                    end
                end
                default: begin
                    n_res.status = ST_BAD;
                end
            endcase
        end
        if (i_cmd.sweep_last) begin
            n_res.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_done   <= 1'b0;
            for (int p = 0; p < NUM_POOLS; p++) begin
                r_free_cnt[p] <= '0;
            end
        end else begin
            r_in_use   <= n_in_use;
            r_free_cnt <= n_free_cnt;
            r_done     <= i_cmd.exec || i_cmd.sweep_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_hit  <= hit;
            r_pick <= pick;
        end
        if (i_cmd.exec || i_cmd.sweep_last) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### design/size_class_block_allocator.sv
`timescale 1ns / 1ps
// Allocate and release: word taken on start, busy while it executes, o_done strobed in the
// cycle after that; a new word is taken only when not busy (read, then update).
// Rebuild: busy while the free-stack memory is swept one slot a cycle over all SLOTS (64)
// slots; result strobed after the sweep. The receiver cannot stall; o_done lasts one cycle.
// Reset (i_rst_n low, synchronous): state, config and done registers, free counts and in-use
// marks clear; stacks stay unwritten until the first rebuild.

module size_class_block_allocator import scba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    // result channel
    output logic        o_done,
    output t_result     o_result,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // register map, 8-byte stride since pool_block_sizes is 64 bits wide
    localparam logic [1:0] REG_TYPES  = 2'd0;
    localparam logic [1:0] REG_SIZES  = 2'd1;
    localparam logic [1:0] REG_COUNTS = 2'd2;

    logic [15:0] r_pool_types;
    logic [63:0] r_pool_block_sizes;
    logic [19:0] r_pool_counts;
    logic        cfg_wr;
    logic [1:0]  reg_sel;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_types       <= '0;
            r_pool_block_sizes <= '0;
            r_pool_counts      <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_TYPES:  r_pool_types       <= pwdata[15:0];
                REG_SIZES:  r_pool_block_sizes <= pwdata;
                REG_COUNTS: r_pool_counts      <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TYPES:  prdata = {48'd0, r_pool_types};
            REG_SIZES:  prdata = r_pool_block_sizes;
            REG_COUNTS: prdata = {44'd0, r_pool_counts};
            default:    prdata = '0;
        endcase
    end

    // types and sizes are live for allocate; counts only matter at rebuild
    assign cfg.pool_types       = r_pool_types;
    assign cfg.pool_block_sizes = r_pool_block_sizes;
    assign cfg.pool_counts      = r_pool_counts;

    // sequencer: idle / execute / sweep
    scba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // pool scan, free-stack memory, counts, in-use marks, result register
    scba_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
